[rtl/svie_pkg.sv]
package svie_pkg;

	typedef enum logic [2:0] {
		OP_PUSH  = 3'd0,
		OP_LOAD  = 3'd1,
		OP_STORE = 3'd2,
		OP_ADD   = 3'd3,
		OP_CMP   = 3'd4,
		OP_JMP   = 3'd5,
		OP_JZ    = 3'd6,
		OP_BAD   = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_UNDER = 2'd1,
		ERR_OVER  = 2'd2,
		ERR_BAD   = 2'd3
	} err_t;

	// Decoded class of one instruction as handed from front to back.
	typedef struct packed {
		op_t  op;
		logic slot_ok;
	} dec_t;

	localparam int unsigned DEC_W = $bits(dec_t);

endpackage

[rtl/svie_front.sv]
module svie_front import svie_pkg::*; #(
	parameter int unsigned LOCAL_COUNT = 16
) (
	input  logic [2:0]  req_type,
	input  logic [31:0] operand,
	output dec_t        dec
);

	// Slot check: non-negative and below the local count.
	always_comb begin
		dec.op      = op_t'(req_type);
		dec.slot_ok = !operand[31] && (operand < 32'(LOCAL_COUNT));
	end

endmodule

[rtl/svie_queue.sv]
module svie_queue #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic             not_empty,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] buf_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign rd_data   = buf_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr_en) wptr_q <= ~wptr_q;
			if (rd_en) rptr_q <= ~rptr_q;
			count_q <= count_q + 2'(wr_en) - 2'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) buf_q[wptr_q] <= wr_data;
	end

endmodule

[rtl/svie_back.sv]
module svie_back import svie_pkg::*; #(
	parameter int unsigned STACK_DEPTH = 64,
	parameter int unsigned LOCAL_COUNT = 16,
	parameter int unsigned PC_WIDTH    = 16,
	localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1),
	localparam int unsigned AW   = $clog2(STACK_DEPTH),
	localparam int unsigned LW   = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  dec_t                dec,
	input  logic [31:0]         opnd,
	input  logic [PC_WIDTH-1:0] pc,
	output logic [PC_WIDTH-1:0] res_pc,
	output logic [31:0]         res_top,
	output logic [SP_W-1:0]     res_depth,
	output err_t                res_err
);

	// Top two entries live in registers, the rest in the memory.
	logic [31:0]     mem [STACK_DEPTH];
	logic [31:0]     locals_q [LOCAL_COUNT];
	logic [SP_W-1:0] sp_q;
	logic [31:0]     top_q;
	logic [31:0]     sec_q;
	logic [31:0]     rd_q;

	logic [SP_W-1:0] nsp;
	logic [31:0]     ntop;
	logic [31:0]     nsec;
	logic            push;
	logic            lwr;
	logic [LW-1:0]   slot;
	logic [31:0]     lval;
	logic [31:0]     sum;
	logic            less;
	logic            mwr;
	logic [AW-1:0]   waddr;
	logic [AW-1:0]   raddr;

	assign slot = opnd[LW-1:0];
	assign lval = locals_q[slot];
	assign sum  = sec_q + top_q;
	assign less = $signed(sec_q) < $signed(top_q);

	always_comb begin
		nsp     = sp_q;
		ntop    = top_q;
		nsec    = sec_q;
		push    = 1'b0;
		lwr     = 1'b0;
		res_err = ERR_OK;
		res_pc  = pc;
		case (dec.op)
			OP_PUSH, OP_LOAD: begin
				if (dec.op == OP_LOAD && !dec.slot_ok) begin
					res_err = ERR_BAD;
				end else if (sp_q == SP_W'(STACK_DEPTH)) begin
					res_err = ERR_OVER;
				end else begin
					push   = 1'b1;
					nsp    = sp_q + 1'b1;
					ntop   = (dec.op == OP_PUSH) ? opnd : lval;
					nsec   = top_q;
					res_pc = pc + PC_WIDTH'(2);
				end
			end
			OP_STORE: begin
				if (!dec.slot_ok) begin
					res_err = ERR_BAD;
				end else if (sp_q == '0) begin
					res_err = ERR_UNDER;
				end else begin
					lwr    = 1'b1;
					nsp    = sp_q - 1'b1;
					ntop   = sec_q;
					nsec   = rd_q;
					res_pc = pc + PC_WIDTH'(2);
				end
			end
			OP_ADD, OP_CMP: begin
				if (sp_q < SP_W'(2)) begin
					res_err = ERR_UNDER;
				end else begin
					nsp    = sp_q - 1'b1;
					ntop   = (dec.op == OP_ADD) ? sum : {31'd0, less};
					nsec   = rd_q;
					res_pc = pc + PC_WIDTH'(1);
				end
			end
			OP_JMP: res_pc = opnd[PC_WIDTH-1:0];
			OP_JZ: begin
				if (sp_q == '0) begin
					res_err = ERR_UNDER;
				end else begin
					nsp    = sp_q - 1'b1;
					ntop   = sec_q;
					nsec   = rd_q;
					res_pc = (top_q == '0) ? opnd[PC_WIDTH-1:0] : pc + PC_WIDTH'(2);
				end
			end
			default: res_err = ERR_BAD;
		endcase
		if (!go) begin
			nsp  = sp_q;
			ntop = top_q;
			nsec = sec_q;
			push = 1'b0;
			lwr  = 1'b0;
		end
		res_top   = (nsp != '0) ? ntop : '0;
		res_depth = nsp;
	end

	// Spill the old second entry on a push; prefetch the entry below the new second.
	assign mwr   = push && (sp_q >= SP_W'(2));
	assign waddr = AW'(sp_q - SP_W'(2));
	assign raddr = AW'(nsp - SP_W'(3));

	always_ff @(posedge clk) begin
		if (mwr) mem[waddr] <= sec_q;
		rd_q <= (mwr && waddr == raddr) ? sec_q : mem[raddr];
		top_q <= ntop;
		sec_q <= nsec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
			for (int i = 0; i < LOCAL_COUNT; i++) locals_q[i] <= '0;
		end else begin
			sp_q <= nsp;
			if (lwr) locals_q[slot] <= top_q;
		end
	end

endmodule

[rtl/stack_vm_instruction_executor_top.sv]
// An input beat enters the two-entry queue, then executes into the output
// register. Throughput: one instruction per cycle while not stalled; the back
// end retires one queued instruction per cycle using registered top/second
// entries and a stack memory with one write and one registered read per cycle.
// Reset (arst_n, asynchronous, active low): stack empty, locals zero, queue
// and output register empty. Stack memory is not cleared.
module stack_vm_instruction_executor_top import svie_pkg::*; #(
	parameter int unsigned STACK_DEPTH = 64,
	parameter int unsigned LOCAL_COUNT = 16,
	parameter int unsigned PC_WIDTH    = 16,
	localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          req_type,
	input  logic [31:0]         operand,
	input  logic [PC_WIDTH-1:0] pc,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [PC_WIDTH-1:0] next_pc,
	output logic [31:0]         top_value,
	output logic [SP_W-1:0]     stack_depth,
	output logic [1:0]          error_code
);

	localparam int unsigned QW = DEC_W + 32 + PC_WIDTH;

	dec_t                dec_f;
	dec_t                dec_b;
	logic [31:0]         opnd_b;
	logic [PC_WIDTH-1:0] pc_b;
	logic [QW-1:0]       q_rd;
	logic                q_full;
	logic                q_ne;
	logic                go;
	logic                in_acc;
	logic [PC_WIDTH-1:0] res_pc;
	logic [31:0]         res_top;
	logic [SP_W-1:0]     res_depth;
	err_t                res_err;
	logic                out_valid_q;

	// Front: classify the opcode and check the slot on the way into the queue.
	svie_front #(.LOCAL_COUNT(LOCAL_COUNT)) u_front (
		.req_type (req_type),
		.operand  (operand),
		.dec      (dec_f)
	);

	assign in_stall = q_full;
	assign in_acc   = in_valid && !q_full;

	svie_queue #(.WIDTH(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (in_acc),
		.wr_data   ({dec_f, operand, pc}),
		.full      (q_full),
		.rd_en     (go),
		.not_empty (q_ne),
		.rd_data   (q_rd)
	);

	assign {dec_b, opnd_b, pc_b} = q_rd;

	// Back: execute when the output register is free or drains this cycle.
	assign go = q_ne && (!out_valid_q || !out_stall);

	svie_back #(
		.STACK_DEPTH (STACK_DEPTH),
		.LOCAL_COUNT (LOCAL_COUNT),
		.PC_WIDTH    (PC_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.dec       (dec_b),
		.opnd      (opnd_b),
		.pc        (pc_b),
		.res_pc    (res_pc),
		.res_top   (res_top),
		.res_depth (res_depth),
		.res_err   (res_err)
	);

	// Output register: load on execute, drop once the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			next_pc     <= res_pc;
			top_value   <= res_top;
			stack_depth <= res_depth;
			error_code  <= res_err;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/svie_checker.sv]
module svie_checker #(
	parameter int unsigned STACK_DEPTH = 64,
	parameter int unsigned PC_WIDTH    = 16,
	localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1)
) (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input logic [PC_WIDTH-1:0] next_pc,
	input logic [31:0]         top_value,
	input logic [SP_W-1:0]     stack_depth,
	input logic [1:0]          error_code
);

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> stack_depth <= SP_W'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stack_depth == '0 |-> top_value == '0)
		else $error("empty stack reports nonzero top");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(next_pc) && $stable(error_code))
		else $error("stalled result beat changed");

endmodule

bind stack_vm_instruction_executor_top svie_checker #(
	.STACK_DEPTH (STACK_DEPTH),
	.PC_WIDTH    (PC_WIDTH)
) u_chk (.*);

[dv/stack_vm_instruction_executor_top_tb.sv]
module stack_vm_instruction_executor_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import svie_pkg::*;

	localparam int STACK_MAX = 64;
	localparam int SLOT_COUNT = 16;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 1750;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  req_type = '0;
	logic [31:0] operand = '0;
	logic [15:0] pc = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] next_pc;
	logic [31:0] top_value;
	logic [6:0]  stack_depth;
	logic [1:0]  error_code;

	typedef struct packed {
		logic [15:0] npc;
		logic [31:0] tos;
		logic [6:0]  depth;
		err_t        err;
	} retire_t;

	typedef struct {
		op_t         op;
		logic [31:0] arg;
		logic [15:0] addr;
		logic        fixed;
		retire_t     want;
	} row_t;

	// Shadow machine state
	logic [31:0] vm_stack [STACK_MAX];
	logic [31:0] vm_slots [SLOT_COUNT];
	int          vm_sp;
	retire_t     retire_q [$];
	int          errors = 0;
	int          idle_cycles = 0;
	bit          quiet_tail = 1'b0;
	bit          hold_sink = 1'b0;
	row_t        dir_rows [$];

	always #1 clk = ~clk;

	stack_vm_instruction_executor_top dut (.*);

	// Execute one instruction on the shadow machine and return its retire beat.
	function automatic retire_t execute_instr(op_t op, logic [31:0] arg, logic [15:0] addr);
		retire_t r;
		logic [15:0] nxt;
		err_t e;
		logic [31:0] a;
		logic [31:0] b;
		bit slot_ok;
		nxt = addr;
		e = ERR_OK;
		slot_ok = !arg[31] && arg < SLOT_COUNT;
		case (op)
			OP_PUSH, OP_LOAD: begin
				if (op == OP_LOAD && !slot_ok) e = ERR_BAD;
				else if (vm_sp >= STACK_MAX) e = ERR_OVER;
				else begin
					vm_stack[vm_sp] = (op == OP_PUSH) ? arg : vm_slots[arg[3:0]];
					vm_sp++;
					nxt = addr + 16'd2;
				end
			end
			OP_STORE: begin
				if (!slot_ok) e = ERR_BAD;
				else if (vm_sp < 1) e = ERR_UNDER;
				else begin
					vm_sp--;
					vm_slots[arg[3:0]] = vm_stack[vm_sp];
					nxt = addr + 16'd2;
				end
			end
			OP_ADD, OP_CMP: begin
				if (vm_sp < 2) e = ERR_UNDER;
				else begin
					b = vm_stack[vm_sp-1];
					a = vm_stack[vm_sp-2];
					vm_sp--;
					vm_stack[vm_sp-1] = (op == OP_ADD) ? a + b :
						($signed(a) < $signed(b) ? 32'd1 : 32'd0);
					nxt = addr + 16'd1;
				end
			end
			OP_JMP: nxt = arg[15:0];
			OP_JZ: begin
				if (vm_sp < 1) e = ERR_UNDER;
				else begin
					vm_sp--;
					nxt = (vm_stack[vm_sp] == 32'd0) ? arg[15:0] : addr + 16'd2;
				end
			end
			default: e = ERR_BAD;
		endcase
		r.npc = nxt;
		r.tos = vm_sp > 0 ? vm_stack[vm_sp-1] : 32'd0;
		r.depth = vm_sp[6:0];
		r.err = e;
		return r;
	endfunction

	function automatic retire_t mk(logic [15:0] n, logic [31:0] t, int d, err_t e);
		retire_t r;
		r.npc = n;
		r.tos = t;
		r.depth = d[6:0];
		r.err = e;
		return r;
	endfunction

	function automatic void add_row(op_t op, logic [31:0] arg, logic [15:0] addr,
		bit fixed = 0, retire_t want = '0);
		row_t r;
		r.op = op;
		r.arg = arg;
		r.addr = addr;
		r.fixed = fixed;
		r.want = want;
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	// Send one beat; predict it at the accepting edge. Valid stays up for the
	// next beat; the caller drops it when the stream pauses.
	task automatic send_beat(op_t op, logic [31:0] arg, logic [15:0] addr,
		bit fixed = 0, retire_t want = '0);
		retire_t r;
		int gap;
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 17);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= op;
		operand <= arg;
		pc <= addr;
		do @(posedge clk); while (in_stall);
		r = execute_instr(op, arg, addr);
		if (fixed && r != want) begin
			errors++;
			$display("%0t directed prediction mismatch: expected %h actual %h",
				$time, want, r);
		end
		retire_q.insert(retire_q.size(), r);
		@(negedge clk);
	endtask

	// Sink stall: random bursts, plus one long hold-off on request.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				out_stall <= 1'b1;
				n = 0;
				while (n < 60) begin
					@(negedge clk);
					n++;
				end
				hold_sink = 1'b0;
				out_stall <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				out_stall <= 1'b0;
			end else out_stall <= 1'b0;
		end
	end

	// Compare each result beat against the oldest expectation.
	always @(posedge clk) begin
		retire_t got;
		retire_t exp;
		if (arst_n && out_valid && !out_stall) begin
			got = mk(next_pc, top_value, stack_depth, err_t'(error_code));
			if (retire_q.size() == 0) begin
				errors++;
				$display("%0t unexpected result beat: actual %h", $time, got);
			end else begin
				exp = retire_q.pop_front();
				if (got.npc !== exp.npc) begin
					errors++;
					$display("%0t next_pc: expected %h actual %h", $time, exp.npc, got.npc);
				end
				if (got.tos !== exp.tos) begin
					errors++;
					$display("%0t top_value: expected %h actual %h", $time, exp.tos, got.tos);
				end
				if (got.depth !== exp.depth) begin
					errors++;
					$display("%0t stack_depth: expected %0d actual %0d",
						$time, exp.depth, got.depth);
				end
				if (got.err !== exp.err) begin
					errors++;
					$display("%0t error_code: expected %0d actual %0d",
						$time, exp.err, got.err);
				end
			end
		end
	end

	// Watchdog: count cycles where no beat moves on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int i;
		int k;
		int depth_goal;
		op_t op;
		logic [31:0] arg;
		logic [15:0] addr;
		vm_sp = 0;
		for (i = 0; i < SLOT_COUNT; i++) vm_slots[i] = '0;
		for (i = 0; i < STACK_MAX; i++) vm_stack[i] = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table: underflows on empty stack, bad opcode/slots, extremes, wraps.
		add_row(OP_ADD, 32'd0, 16'h0010, 1, mk(16'h0010, 0, 0, ERR_UNDER));
		add_row(OP_STORE, 32'd0, 16'h0020, 1, mk(16'h0020, 0, 0, ERR_UNDER));
		add_row(OP_JZ, 32'd5, 16'h0030, 1, mk(16'h0030, 0, 0, ERR_UNDER));
		add_row(OP_BAD, 32'hFFFF_FFFF, 16'hFFFF, 1, mk(16'hFFFF, 0, 0, ERR_BAD));
		add_row(OP_LOAD, 32'h8000_0000, 16'h0001, 1, mk(16'h0001, 0, 0, ERR_BAD));
		add_row(OP_LOAD, 32'd16, 16'h0002, 1, mk(16'h0002, 0, 0, ERR_BAD));
		add_row(OP_STORE, 32'hFFFF_FFFF, 16'h0003, 1, mk(16'h0003, 0, 0, ERR_BAD));
		add_row(OP_LOAD, 32'd15, 16'hFFFF, 1, mk(16'h0001, 0, 1, ERR_OK));
		add_row(OP_PUSH, 32'h7FFF_FFFF, 16'hFFFE, 1, mk(16'h0000, 32'h7FFF_FFFF, 2, ERR_OK));
		add_row(OP_PUSH, 32'h0000_0001, 16'h0004);
		add_row(OP_ADD, 32'd0, 16'hFFFF, 1, mk(16'h0000, 32'h8000_0000, 2, ERR_OK));
		add_row(OP_PUSH, 32'h8000_0000, 16'h0005);
		add_row(OP_CMP, 32'd0, 16'h0006);
		add_row(OP_STORE, 32'd15, 16'h0007);
		add_row(OP_LOAD, 32'd15, 16'h0008);
		add_row(OP_JZ, 32'hABCD_1234, 16'h0009);
		add_row(OP_PUSH, 32'd0, 16'h000A);
		add_row(OP_JZ, 32'h5555_AAAA, 16'h000B);
		add_row(OP_JMP, 32'hFFFF_FFFF, 16'h000C, 1, mk(16'hFFFF, 0, 1, ERR_OK));
		add_row(OP_JMP, 32'h0000_0000, 16'hFFFF);
		foreach (dir_rows[j])
			send_beat(dir_rows[j].op, dir_rows[j].arg, dir_rows[j].addr,
				dir_rows[j].fixed, dir_rows[j].want);

		// Fill to overflow while the sink holds off, so the input backs up.
		hold_sink = 1'b1;
		while (vm_sp < STACK_MAX)
			send_beat(OP_PUSH, $urandom, 16'($urandom));
		send_beat(OP_PUSH, 32'd1, 16'h0100);
		send_beat(OP_LOAD, 32'd3, 16'h0101);
		// Sender pause: drop valid and wait for the pipeline to drain completely.
		in_valid <= 1'b0;
		wait (retire_q.size() == 0);
		@(negedge clk);

		// Random program fragments, with a drifting target depth.
		k = 0;
		depth_goal = 8;
		while (k < RANDOM_ITEMS) begin
			if (k == RANDOM_ITEMS - 150) quiet_tail = 1'b1;
			if ($urandom_range(0, 99) == 0) depth_goal = $urandom_range(0, STACK_MAX + 2);
			addr = 16'($urandom);
			case ($urandom_range(0, 9))
				0: arg = $urandom;
				1: arg = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
				2: arg = 32'($urandom_range(0, 20)) | ($urandom_range(0, 3) == 0 ?
					32'h8000_0000 : 32'h0);
				default: arg = $urandom_range(0, SLOT_COUNT - 1);
			endcase
			if ($urandom_range(0, 19) == 0) op = op_t'($urandom_range(0, 7));
			else if (vm_sp < depth_goal)
				op = $urandom_range(0, 2) == 0 ? OP_LOAD : OP_PUSH;
			else
				case ($urandom_range(0, 5))
					0: op = OP_STORE;
					1: op = OP_ADD;
					2: op = OP_CMP;
					3: op = OP_JZ;
					4: op = OP_JMP;
					default: op = OP_PUSH;
				endcase
			if (op == OP_PUSH && $urandom_range(0, 3) == 0) arg = 32'($urandom_range(0, 1));
			send_beat(op, arg, addr);
			k++;
		end
		in_valid <= 1'b0;

		i = 0;
		while (retire_q.size() != 0 && i < WATCHDOG_LIMIT) begin
			@(negedge clk);
			i++;
		end
		repeat (20) @(negedge clk);
		if (errors == 0 && retire_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/svie_pkg.sv
rtl/svie_front.sv
rtl/svie_queue.sv
rtl/svie_back.sv
rtl/stack_vm_instruction_executor_top.sv
rtl/svie_checker.sv
dv/stack_vm_instruction_executor_top_tb.sv
